// File: design/epv_pkg.sv
// ----------------------------------------------------------------------------
// Encoder position/velocity package
// Shared widths, register map and constants.
// ----------------------------------------------------------------------------
package epv_pkg;

    localparam int CNT_W  = 16;
    localparam int TS_W   = 32;
    localparam int MM_W   = 20;
    localparam int OUT_W  = 52;
    localparam int ACC_W  = 32;
    localparam int DLT_W  = 17;
    localparam int QUO_W  = 35;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [MM_W-1:0] US_PER_S          = 20'd1000000;
    localparam logic [TS_W-1:0] STOP_TIMEOUT_RST  = 32'd100000;
    localparam logic [MM_W-1:0] MM_PER_TICK_RST   = 20'd42893;

    localparam logic REG_STOP_TIMEOUT = 1'b0;
    localparam logic REG_MM_PER_TICK  = 1'b1;

endpackage

// File: design/epv_if.sv
// ----------------------------------------------------------------------------
// Encoder position/velocity channels
// Valid/ready channels for encoder samples and position/velocity results.
// ----------------------------------------------------------------------------
interface epv_sample_if
    import epv_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  counter_value;
    logic [TS_W-1:0]   timestamp_us;

    modport source (output valid, output counter_value, output timestamp_us, input ready);
    modport sink   (input valid, input counter_value, input timestamp_us, output ready);
endinterface

interface epv_result_if
    import epv_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  position_mm_q16;
    logic signed [OUT_W-1:0]  velocity_mm_s_q16;

    modport source (output valid, output position_mm_q16, output velocity_mm_s_q16,
                    input ready);
    modport sink   (input valid, input position_mm_q16, input velocity_mm_s_q16,
                    output ready);
endinterface

// File: design/epv_mult.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Registered signed 32 x unsigned 20 product, truncated to 52 bits.
// ----------------------------------------------------------------------------
module epv_mult
    import epv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [ACC_W-1:0]  i_a,
    input  logic [MM_W-1:0]          i_b,
    output logic signed [OUT_W-1:0]  o_p
);

    logic signed [ACC_W+MM_W:0] w_full;
    logic signed [OUT_W-1:0]    r_prod;

    assign w_full = $signed(i_a) * $signed({1'b0, i_b});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_full[OUT_W-1:0];
        end
    end

    assign o_p = r_prod;

endmodule

// File: design/epv_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module epv_div
    import epv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [QUO_W-1:0]   i_dividend,
    input  logic [TS_W-1:0]    i_divisor,
    output logic               o_done,
    output logic [QUO_W-1:0]   o_quotient
);

    localparam int CW = $clog2(QUO_W + 1);

    logic [TS_W-1:0]   r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [TS_W-1:0]   r_div;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [TS_W:0]     w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? TS_W'(w_trial - {1'b0, r_div}) : w_trial[TS_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: design/encoder_position_velocity_core.sv
// ----------------------------------------------------------------------------
// Encoder position/velocity core
// Samples are taken only in S_IDLE: a moved counter runs S_DELTA, S_MUL, S_DSTART,
// the 35-step serial divider, S_POS, S_VEL and S_FIN (else S_DELTA, S_POS, S_VEL,
// S_FIN), and one multiplier serves all three products. S_FIN waits for output room.
// Reset: i_rst_n synchronous active low; clears state and loads register
// defaults (timeout 100000 us, 42893 mm/tick Q16).
// ----------------------------------------------------------------------------
module encoder_position_velocity_core
    import epv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    epv_sample_if.sink          i_sample,
    epv_result_if.source        o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DELTA  = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_POS    = 3'd5;
    localparam logic [2:0] S_VEL    = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0]               r_state;
    logic [TS_W-1:0]          r_timeout;
    logic [MM_W-1:0]          r_mm;
    logic [CNT_W-1:0]         r_prev;
    logic [ACC_W-1:0]         r_tick;
    logic [ACC_W-1:0]         r_speed;
    logic [TS_W-1:0]          r_last_move;
    logic [CNT_W-1:0]         r_cnt_in;
    logic [TS_W-1:0]          r_ts;
    logic signed [DLT_W-1:0]  r_delta;
    logic [TS_W-1:0]          r_elapsed;
    logic signed [OUT_W-1:0]  r_pos;
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_out_pos;
    logic signed [OUT_W-1:0]  r_out_vel;

    logic signed [DLT_W:0]    w_raw;
    logic signed [DLT_W-1:0]  w_delta;
    logic [TS_W-1:0]          w_elapsed;
    logic [DLT_W-1:0]         w_abs;
    logic                     w_mul_en;
    logic signed [ACC_W-1:0]  w_mul_a;
    logic [MM_W-1:0]          w_mul_b;
    logic signed [OUT_W-1:0]  w_prod;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [QUO_W-1:0]         w_quo;
    logic [ACC_W-1:0]         w_sat;
    logic                     w_cfg_wr;
    logic                     w_out_free;

    // delta with counter wrap correction
    always_comb begin
        w_raw = $signed({2'b00, r_cnt_in}) - $signed({2'b00, r_prev});
        if (w_raw > 18'sd32767) begin
            w_raw = w_raw - 18'sd65536;
        end else if (w_raw < -18'sd32767) begin
            w_raw = w_raw + 18'sd65536;
        end
        w_delta = w_raw[DLT_W-1:0];
    end

    assign w_elapsed = r_ts - r_last_move;
    assign w_abs     = r_delta[DLT_W-1] ? DLT_W'(-r_delta) : DLT_W'(r_delta);

    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = $signed(r_tick);
        w_mul_b  = r_mm;
        unique case (r_state)
            S_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed({{(ACC_W-DLT_W){1'b0}}, w_abs});
                w_mul_b  = US_PER_S;
            end
            S_POS: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed(r_tick);
            end
            S_VEL: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed(r_speed);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    epv_mult u_mult (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign w_div_start = (r_state == S_DSTART);

    epv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod[QUO_W-1:0]),
        .i_divisor  ((r_elapsed == '0) ? TS_W'(1) : r_elapsed),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // truncated quotient magnitude, signed and saturated to 32 bits
    always_comb begin
        if (!r_delta[DLT_W-1]) begin
            w_sat = (w_quo > QUO_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : w_quo[ACC_W-1:0];
        end else begin
            w_sat = (w_quo > QUO_W'(32'h8000_0000)) ? 32'h8000_0000
                                                    : ACC_W'(-w_quo[ACC_W-1:0]);
        end
    end

    assign w_out_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_tick      <= '0;
            r_speed     <= '0;
            r_last_move <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_sample.valid) begin
                        r_state <= S_DELTA;
                    end
                end
                S_DELTA: begin
                    r_prev <= r_cnt_in;
                    r_tick <= r_tick + ACC_W'(w_delta);
                    if (w_delta != '0) begin
                        r_state <= S_MUL;
                    end else begin
                        if (w_elapsed > r_timeout) begin
                            r_speed <= '0;
                        end
                        r_state <= S_POS;
                    end
                end
                S_MUL: begin
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_last_move <= r_ts;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_speed <= w_sat;
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    r_state <= S_VEL;
                end
                S_VEL: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_sample.valid) begin
            r_cnt_in <= i_sample.counter_value;
            r_ts     <= i_sample.timestamp_us;
        end
        if (r_state == S_DELTA) begin
            r_delta   <= w_delta;
            r_elapsed <= w_elapsed;
        end
        if (r_state == S_VEL) begin
            r_pos <= w_prod;
        end
        if (r_state == S_FIN && w_out_free) begin
            r_out_pos <= r_pos;
            r_out_vel <= w_prod;
        end
    end

    // configuration registers
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= STOP_TIMEOUT_RST;
            r_mm      <= MM_PER_TICK_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_STOP_TIMEOUT) begin
                r_timeout <= pwdata;
            end else begin
                r_mm <= pwdata[MM_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_MM_PER_TICK) ? {{(DATA_W-MM_W){1'b0}}, r_mm} : r_timeout;
    assign pready = 1'b1;

    assign i_sample.ready             = (r_state == S_IDLE);
    assign o_result.valid             = r_out_valid;
    assign o_result.position_mm_q16   = r_out_pos;
    assign o_result.velocity_mm_s_q16 = r_out_vel;

endmodule
